/* hdl/fatcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatcw_pkg
// Shared types and constants of the FAT12 cluster chain walker.
// ----------------------------------------------------------------------------
package fatcw_pkg;

  localparam int FAT_BYTES_DEF = 8192;
  localparam int QDEPTH        = 2;

  localparam int REQ_W     = 2;
  localparam int FADDR_W   = 13;
  localparam int BYTE_W    = 8;
  localparam int CLUSTER_W = 12;
  localparam int LBA_W     = 20;
  localparam int ROOT_W    = 16;
  localparam int SPC_W     = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPC  = 1'b1;

  localparam logic [ROOT_W-1:0]    ROOT_RESET = 16'd33;
  localparam logic [SPC_W-1:0]     SPC_RESET  = 8'd1;
  localparam logic [CLUSTER_W-1:0] END_MARK   = 12'hFF8;
  localparam logic [CLUSTER_W-1:0] FIRST_DATA = 12'd2;
  localparam logic [BYTE_W-1:0]    BYTE_OOB   = 8'hFF;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_STEP
  } op_t;

  typedef enum logic [1:0] {
    STS_OK,
    STS_NO_CHAIN,
    STS_LOW_CLUSTER
  } status_t;

  typedef struct packed {
    op_t                  op;
    logic [FADDR_W-1:0]   addr;
    logic [BYTE_W-1:0]    data;
    logic [CLUSTER_W-1:0] first;
  } q_item_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [SPC_W-1:0]  spc;
  } cfg_t;

  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [LBA_W-1:0]     lba;
    logic                 last;
    status_t              status;
  } result_t;

endpackage

/* hdl/fatcw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatcw_front
// Input side: unpacks request words, classifies them and pushes them into
// the request queue; reserved request types are consumed and dropped.
// ----------------------------------------------------------------------------
module fatcw_front (
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [39:0]            in_tdata,   // fat_address, fat_byte, first_cluster
  input  logic [1:0]             in_tuser,   // req_type
  input  logic                   q_full,
  output logic                   q_push,
  output fatcw_pkg::q_item_t     q_item
);
  import fatcw_pkg::*;

  logic kind_ok;

  always_comb begin
    q_item.addr  = in_tdata[FADDR_W-1:0];
    q_item.data  = in_tdata[FADDR_W+BYTE_W-1:FADDR_W];
    q_item.first = in_tdata[FADDR_W+BYTE_W+CLUSTER_W-1:FADDR_W+BYTE_W];
    q_item.op    = OP_LOAD;
    kind_ok      = 1'b1;
    unique case (in_tuser)
      REQ_LOAD:  q_item.op = OP_LOAD;
      REQ_START: q_item.op = OP_START;
      REQ_STEP:  q_item.op = OP_STEP;
      default:   kind_ok   = 1'b0;
    endcase
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && kind_ok;

endmodule

/* hdl/fatcw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatcw_queue
// Short request queue between the front and the back end.
// ----------------------------------------------------------------------------
module fatcw_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fatcw_pkg::q_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output fatcw_pkg::q_item_t head
);
  import fatcw_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  q_item_t            slot_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(QDEPTH));
  assign valid   = (count_r != '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

/* hdl/fatcw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fatcw_back
// Back end: FAT byte store, chain state, entry read and decode, sector
// address computation and the output register.
// ----------------------------------------------------------------------------
module fatcw_back #(
  parameter int FAT_BYTES = fatcw_pkg::FAT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fatcw_pkg::cfg_t     cfg,
  input  logic                q_valid,
  input  fatcw_pkg::q_item_t  q_head,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output fatcw_pkg::result_t  res
);
  import fatcw_pkg::*;

  localparam int ADDR_W = (FAT_BYTES > 1) ? $clog2(FAT_BYTES) : 1;
  localparam logic [FADDR_W:0] FAT_LIMIT = (FADDR_W + 1)'(FAT_BYTES);

  typedef enum logic {
    ST_IDLE,
    ST_WAIT
  } state_t;

  state_t                   state_r;
  logic                     active_r;
  logic [CLUSTER_W-1:0]     cur_r;
  logic                     out_valid_r;
  result_t                  out_r;

  logic [CLUSTER_W-1:0]     clus_r;
  logic                     odd_r;
  logic                     oob_lo_r, oob_hi_r;
  logic [LBA_W-1:0]         prod_r;
  logic [BYTE_W-1:0]        rd_lo_r, rd_hi_r;
  logic [BYTE_W-1:0]        fat_mem [FAT_BYTES];

  logic [FADDR_W-1:0]       off_lo, off_hi;
  logic                     out_free, issue_rd, mem_we, out_load;
  logic [BYTE_W-1:0]        byte_lo, byte_hi;
  logic [2*BYTE_W-1:0]      pair;
  logic [CLUSTER_W-1:0]     entry;
  logic                     entry_last;
  logic [LBA_W:0]           lba_sum;
  logic [LBA_W-1:0]         lba_sat;
  logic [LBA_W-1:0]         prod;

  always_comb begin
    off_lo   = FADDR_W'(cur_r) + FADDR_W'(cur_r[CLUSTER_W-1:1]);
    off_hi   = off_lo + 1'b1;
    out_free = !out_valid_r || res_ready;
    issue_rd = (state_r == ST_IDLE) && q_valid && (q_head.op == OP_STEP) && active_r &&
               (cur_r >= FIRST_DATA);
    mem_we   = (state_r == ST_IDLE) && q_valid && (q_head.op == OP_LOAD) &&
               ({1'b0, q_head.addr} < FAT_LIMIT);
    q_pop    = (state_r == ST_IDLE) && q_valid &&
               ((q_head.op != OP_STEP) || issue_rd || out_free);
    out_load = out_free &&
               (((state_r == ST_IDLE) && q_valid && (q_head.op == OP_STEP) && !issue_rd) ||
                (state_r == ST_WAIT));
    prod     = LBA_W'(cur_r - FIRST_DATA) * LBA_W'(cfg.spc);

    byte_lo    = oob_lo_r ? BYTE_OOB : rd_lo_r;
    byte_hi    = oob_hi_r ? BYTE_OOB : rd_hi_r;
    pair       = {byte_hi, byte_lo};
    entry      = odd_r ? pair[15:4] : pair[11:0];
    entry_last = (entry >= END_MARK);
    lba_sum    = (LBA_W + 1)'(cfg.root) + (LBA_W + 1)'(prod_r);
    lba_sat    = lba_sum[LBA_W] ? {LBA_W{1'b1}} : lba_sum[LBA_W-1:0];
  end

  // fat store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fat_mem[q_head.addr[ADDR_W-1:0]] <= q_head.data;
    end
    if (issue_rd) begin
      rd_lo_r <= fat_mem[off_lo[ADDR_W-1:0]];
      rd_hi_r <= fat_mem[off_hi[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && res_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_head.op)
              OP_LOAD: begin
              end
              OP_START: begin
                cur_r    <= q_head.first;
                active_r <= 1'b1;
              end
              OP_STEP: begin
                if (issue_rd) begin
                  state_r  <= ST_WAIT;
                  clus_r   <= cur_r;
                  odd_r    <= cur_r[0];
                  oob_lo_r <= ({1'b0, off_lo} >= FAT_LIMIT);
                  oob_hi_r <= ({1'b0, off_hi} >= FAT_LIMIT);
                  prod_r   <= prod;
                end else if (out_free) begin
                  out_r.lba   <= '0;
                  if (!active_r) begin
                    out_r.cluster <= '0;
                    out_r.last    <= 1'b0;
                    out_r.status  <= STS_NO_CHAIN;
                  end else begin
                    out_r.cluster <= cur_r;
                    out_r.last    <= 1'b1;
                    out_r.status  <= STS_LOW_CLUSTER;
                    active_r      <= 1'b0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_WAIT: begin
          if (out_free) begin
            out_r.cluster <= clus_r;
            out_r.lba     <= lba_sat;
            out_r.last    <= entry_last;
            out_r.status  <= STS_OK;
            cur_r         <= entry;
            if (entry_last) begin
              active_r <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  a_wait_needs_chain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT |-> active_r)
    else $error("entry read pending without an active chain");

  a_wait_finishes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WAIT && out_free |=> state_r == ST_IDLE && out_valid_r)
    else $error("entry read did not complete into the output register");

  a_ok_cluster: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == STS_OK |-> out_r.cluster >= FIRST_DATA)
    else $error("ok result carries a cluster below two");

  a_no_chain_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == STS_NO_CHAIN |->
      out_r.cluster == '0 && out_r.lba == '0 && !out_r.last)
    else $error("no-chain result has nonzero fields");

  a_pop_step_read: assert property (@(posedge clk) disable iff (!rst_n)
    issue_rd |-> q_pop && !mem_we)
    else $error("entry read issued without taking the request");

endmodule

/* hdl/fat12_cluster_chain_walker_core.sv */
`timescale 1ns / 1ps
// step with an active chain: the two-byte fat entry read from the synchronous store, then
// entry decode, lba add and output register load
// load, start and steps answered by status alone: no entry read
// reset: rst_n synchronous active low clears queue, chain state and output valid,
// loads root_dir_end_lba 33 and sectors_per_cluster 1; fat store contents stay undefined
// ----------------------------------------------------------------------------
// fat12_cluster_chain_walker_core
// FAT12 cluster chain walker: loads a fat byte by byte and follows a file's
// cluster chain, giving each cluster's sector address and end-of-chain flag.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker_core #(
  parameter int FAT_BYTES = fatcw_pkg::FAT_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // fat_address[12:0], fat_byte[20:13], first_cluster[32:21]
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cluster[11:0], sector_lba[31:12]
  output logic        out_tlast,  // is_last
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_we,
  input  logic [fatcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fatcw_pkg::CFG_W-1:0]     cfg_wdata
);
  import fatcw_pkg::*;

  cfg_t    cfg_r;
  logic    q_full, q_push, q_valid, q_pop;
  q_item_t push_item, q_head;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.root <= ROOT_RESET;
      cfg_r.spc  <= SPC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROOT: cfg_r.root <= cfg_wdata[ROOT_W-1:0];
        CFG_SPC:  cfg_r.spc  <= cfg_wdata[SPC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fatcw_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  fatcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  fatcw_back #(
    .FAT_BYTES (FAT_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.lba, res.cluster};
  assign out_tlast = res.last;
  assign out_tuser = res.status;

endmodule

/* tb/fat12_chain_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_chain_checker
// Watches the word, result and register ports of the FAT12 chain walker,
// keeps its own FAT image and chain cursor, predicts every step result and
// compares each result word field by field in arrival order.
// ----------------------------------------------------------------------------
module fat12_chain_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [39:0]                     in_tdata,   // fat_address, fat_byte, first_cluster
  input  logic [1:0]                      in_tuser,   // req_type
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [31:0]                     out_tdata,  // cluster, sector_lba
  input  logic                            out_tlast,  // is_last
  input  logic [1:0]                      out_tuser,  // status
  input  logic                            cfg_we,
  input  logic [fatcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fatcw_pkg::CFG_W-1:0]     cfg_wdata,
  output int                              errors,
  output int                              pending,
  output int                              checked
);
  import fatcw_pkg::*;

  bit   [BYTE_W-1:0]    fat_img [FAT_BYTES_DEF];
  logic [ROOT_W-1:0]    root_lba;
  logic [SPC_W-1:0]     spc;
  logic [CLUSTER_W-1:0] cursor;
  bit                   walking;
  result_t              due_results [$];
  result_t              want;

  function automatic logic [CLUSTER_W-1:0] entry_of(input logic [CLUSTER_W-1:0] c);
    int unsigned off;
    logic [15:0] pair;
    off  = (int'(c) * 3) / 2;
    pair = {fat_img[off + 1], fat_img[off]};
    return c[0] ? pair[15:4] : pair[11:0];
  endfunction

  function automatic result_t walk_step();
    result_t              r;
    int unsigned          lba;
    logic [CLUSTER_W-1:0] nxt;
    r = '0;
    if (!walking) begin
      r.status = STS_NO_CHAIN;
      return r;
    end
    r.cluster = cursor;
    if (cursor < FIRST_DATA) begin
      walking  = 1'b0;
      r.last   = 1'b1;
      r.status = STS_LOW_CLUSTER;
      return r;
    end
    lba = int'(root_lba) + (int'(cursor) - int'(FIRST_DATA)) * int'(spc);
    if (lba > 32'hFFFFF) lba = 32'hFFFFF;
    nxt      = entry_of(cursor);
    r.lba    = LBA_W'(lba);
    r.last   = (nxt >= END_MARK);
    r.status = STS_OK;
    cursor   = nxt;
    if (r.last) walking = 1'b0;
    return r;
  endfunction

  task automatic field_check(input string name, input int unsigned exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      root_lba = ROOT_RESET;
      spc      = SPC_RESET;
      cursor   = '0;
      walking  = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROOT: root_lba = cfg_wdata[ROOT_W-1:0];
          CFG_SPC:  spc      = cfg_wdata[SPC_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, got tdata %0h last %0b status %0d",
                   $time, out_tdata, out_tlast, out_tuser);
        end else begin
          want = due_results.pop_front();
          checked++;
          field_check("cluster", want.cluster, {20'd0, out_tdata[11:0]});
          field_check("sector_lba", want.lba, {12'd0, out_tdata[31:12]});
          field_check("is_last", want.last, {31'd0, out_tlast});
          field_check("status", want.status, {30'd0, out_tuser});
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          REQ_LOAD:  fat_img[in_tdata[12:0]] = in_tdata[20:13];
          REQ_START: begin
            cursor  = in_tdata[32:21];
            walking = 1'b1;
          end
          REQ_STEP:  due_results.push_back(walk_step());
          default: ;
        endcase
      end
    end
    pending = due_results.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the FAT12 chain walker with FAT entry loads, chain starts and steps
// under random idling on both sides, a long receiver hold-off per setting and
// several register settings, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import fatcw_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE   = 2'd3;
  localparam int               PHASES      = 5;
  localparam int               PHASE_WORDS = 250;
  localparam int               HOLD_CYCLES = 400;
  localparam int               CYCLE_LIMIT = 200000;
  localparam int               NPAIRS      = 2048;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [39:0]          in_tdata;
  logic [1:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;
  logic                 out_tlast;
  logic [1:0]           out_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int errors;
  int pending;
  int checked;

  bit          quiet;
  bit          hold_req;
  int          hold_count;
  int          words_sent;
  int          loads_sent;
  int          starts_sent;
  int          steps_sent;
  bit          pair_ok [NPAIRS];
  int unsigned pair_list [$];
  bit          chain_safe;

  fat12_cluster_chain_walker_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  fat12_chain_checker chain_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off when asked
  initial begin : sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_count++;
        stall_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else if (quiet || !rst_n) begin
        out_tready <= rst_n;
      end else begin
        out_tready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [REQ_W-1:0] req, input logic [FADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data,
                           input logic [CLUSTER_W-1:0] first);
    while (!quiet && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'd0, first, data, addr};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (req != REQ_SPARE) words_sent++;
  endtask

  task automatic send_load(input logic [FADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
    send_word(REQ_LOAD, addr, data, CLUSTER_W'($urandom));
    loads_sent++;
  endtask

  task automatic send_start(input logic [CLUSTER_W-1:0] c);
    send_word(REQ_START, FADDR_W'($urandom), BYTE_W'($urandom), c);
    chain_safe = (c < FIRST_DATA) || pair_ok[c >> 1];
    starts_sent++;
  endtask

  task automatic send_step();
    send_word(REQ_STEP, FADDR_W'($urandom), BYTE_W'($urandom), CLUSTER_W'($urandom));
    steps_sent++;
  endtask

  task automatic send_spare();
    send_word(REQ_SPARE, FADDR_W'($urandom), BYTE_W'($urandom), CLUSTER_W'($urandom));
  endtask

  // clusters 2k and 2k+1 share the three bytes at 3k
  task automatic load_pair(input int unsigned k, input logic [CLUSTER_W-1:0] e0,
                           input logic [CLUSTER_W-1:0] e1);
    logic [FADDR_W-1:0] base;
    base = FADDR_W'(3 * k);
    send_load(base, e0[7:0]);
    send_load(base + FADDR_W'(1), {e1[3:0], e0[11:8]});
    send_load(base + FADDR_W'(2), e1[11:4]);
    if (!pair_ok[k]) begin
      pair_ok[k] = 1'b1;
      pair_list.push_back(k);
    end
  endtask

  function automatic logic [CLUSTER_W-1:0] any_live_cluster();
    int unsigned k;
    k = pair_list[$urandom_range(pair_list.size() - 1)];
    return CLUSTER_W'(2 * k + $urandom_range(1));
  endfunction

  // links stay inside written entries, end marks or clusters below two
  function automatic logic [CLUSTER_W-1:0] pick_link();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return END_MARK + CLUSTER_W'($urandom_range(7));
    if (r < 32) return CLUSTER_W'($urandom_range(1));
    return any_live_cluster();
  endfunction

  task automatic write_pair(input int unsigned k);
    logic [CLUSTER_W-1:0] e0;
    logic [CLUSTER_W-1:0] e1;
    e0 = pick_link();
    e1 = pick_link();
    load_pair(k, e0, e1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [ROOT_W-1:0] roots [PHASES];
    logic [SPC_W-1:0]  spcs [PHASES];
    int                base;
    int unsigned       r;
    bit                held;

    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    rst_n       = 1'b0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    hold_count  = 0;
    words_sent  = 0;
    loads_sent  = 0;
    starts_sent = 0;
    steps_sent  = 0;
    chain_safe  = 1'b1;
    roots = '{ROOT_RESET, 16'd0, 16'hFFFF, 16'hFFFF, ROOT_W'($urandom)};
    spcs  = '{SPC_RESET, 8'd128, 8'd1, 8'd128, SPC_W'($urandom_range(128, 1))};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: short chain, chain through the top clusters and 0xff0 range,
    // step with no chain, clusters below two, top fat address, unused request
    load_pair(1, 12'd3, END_MARK);
    load_pair(12'hFF0 >> 1, 12'hFF1, 12'hFFF);
    load_pair(NPAIRS - 1, 12'hFF0, 12'd4094);
    send_load(13'h1FFF, 8'hFF);
    send_step();
    send_start(12'd0);
    send_step();
    send_start(12'd1);
    send_step();
    send_start(12'd2);
    repeat (3) send_step();
    send_start(12'hFFF);
    repeat (4) send_step();
    send_spare();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        write_reg(CFG_ROOT, roots[phase]);
        write_reg(CFG_SPC, {8'd0, spcs[phase]});
      end
      quiet = (phase == 2);
      base  = words_sent;
      held  = 1'b0;
      while (words_sent - base < PHASE_WORDS) begin
        r = $urandom_range(99);
        if (r < 22) begin
          if ($urandom_range(4) == 0) write_pair($urandom_range(NPAIRS - 1));
          else write_pair($urandom_range(24));
        end else if (r < 36) begin
          r = $urandom_range(99);
          if (r < 70) send_start(any_live_cluster());
          else if (r < 80) send_start(CLUSTER_W'($urandom_range(1)));
          else send_start(CLUSTER_W'($urandom));
        end else if (r < 88) begin
          if (!chain_safe) send_start(any_live_cluster());
          repeat ($urandom_range(8, 1)) send_step();
        end else if (r < 95) begin
          // bytes above every reachable entry
          send_load(FADDR_W'($urandom_range(8191, 6144)), BYTE_W'($urandom));
        end else begin
          send_spare();
        end
        if (!held && words_sent - base >= 100) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
      end
    end

    drain();
    $display("summary: %0d words (%0d fat loads, %0d starts, %0d steps), %0d results checked",
             words_sent, loads_sent, starts_sent, steps_sent, checked);
    $display("summary: %0d register settings incl. extremes, %0d long receiver hold-offs",
             PHASES, hold_count);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
